[hdl/sbs_pkg.sv]
// Package for the sorted table binary search block.
// Table geometry, operation codes, controller states and the RAM request type.
// No dependencies.
package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int POS_W       = 10;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_ram_req;

endpackage

[hdl/sbs_ram.sv]
// Table store: one write port, one read port, registered read data.
// Depends on sbs_pkg.
module sbs_ram (
    input  logic                             i_clk,
    input  sbs_pkg::t_ram_req                i_req,
    output logic signed [sbs_pkg::WORD_W-1:0] o_rdata
);

    logic signed [sbs_pkg::WORD_W-1:0] r_mem [sbs_pkg::TABLE_DEPTH];
    logic signed [sbs_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sbs_ctrl.sv]
// Search controller: takes beats, narrows the window one table read per cycle.
// Depends on sbs_pkg; drives the request port of sbs_ram.
module sbs_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [sbs_pkg::POS_W-1:0]         i_entry_index,
    input  logic signed [sbs_pkg::WORD_W-1:0] i_data_word,
    input  logic [sbs_pkg::POS_W-1:0]         i_window_low,
    input  logic [sbs_pkg::POS_W-1:0]         i_window_high,
    input  logic signed [sbs_pkg::WORD_W-1:0] i_rdata,
    output sbs_pkg::t_ram_req                 o_req,
    output logic                              o_strobe,
    output logic                              o_found,
    output logic [sbs_pkg::POS_W-1:0]         o_position
);

    sbs_pkg::t_state r_state, n_state;

    logic signed [sbs_pkg::WORD_W-1:0] r_key, n_key;
    logic [sbs_pkg::POS_W-1:0]         r_lo, n_lo, r_hi, n_hi;
    logic                              r_strobe, n_strobe;
    logic                              r_found, n_found;
    logic [sbs_pkg::POS_W-1:0]         r_pos, n_pos;

    logic                              accept;
    logic [sbs_pkg::POS_W-1:0]         sat_hi;
    logic [sbs_pkg::POS_W:0]           in_sum, cur_sum, upd_sum;
    logic [sbs_pkg::POS_W-1:0]         in_mid, cur_mid, upd_mid;
    logic [sbs_pkg::POS_W-1:0]         upd_lo, upd_hi;
    logic                              key_le;
    logic [sbs_pkg::POS_W-1:0]         rd_pos;

    assign accept = start && !busy;

    always_comb begin
        if (32'(i_window_high) >= 32'(sbs_pkg::TABLE_DEPTH)) begin
            sat_hi = sbs_pkg::POS_W'(sbs_pkg::TABLE_DEPTH - 1);
        end else begin
            sat_hi = i_window_high;
        end
        in_sum  = {1'b0, i_window_low} + {1'b0, sat_hi};
        in_mid  = in_sum[sbs_pkg::POS_W:1];
        cur_sum = {1'b0, r_lo} + {1'b0, r_hi};
        cur_mid = cur_sum[sbs_pkg::POS_W:1];
        key_le  = r_key <= i_rdata;
        upd_lo  = key_le ? r_lo : cur_mid + 1'b1;
        upd_hi  = key_le ? cur_mid : r_hi;
        upd_sum = {1'b0, upd_lo} + {1'b0, upd_hi};
        upd_mid = upd_sum[sbs_pkg::POS_W:1];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbs_pkg::ST_IDLE: begin
                if (accept && i_op == sbs_pkg::OP_SEARCH) begin
                    if (i_window_low < sat_hi) begin
                        n_state = sbs_pkg::ST_LOOK;
                    end else if (i_window_low == sat_hi) begin
                        n_state = sbs_pkg::ST_LAST;
                    end
                end
            end
            sbs_pkg::ST_LOOK: begin
                if (upd_lo == upd_hi) begin
                    n_state = sbs_pkg::ST_LAST;
                end
            end
            sbs_pkg::ST_LAST: begin
                n_state = sbs_pkg::ST_IDLE;
            end
            default: n_state = sbs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_strobe = 1'b0;
        n_found  = r_found;
        n_pos    = r_pos;
        rd_pos   = r_lo;
        o_req.we    = 1'b0;
        o_req.waddr = i_entry_index[sbs_pkg::ADDR_W-1:0];
        o_req.wdata = i_data_word;
        unique case (r_state)
            sbs_pkg::ST_IDLE: begin
                rd_pos = (i_window_low < sat_hi) ? in_mid : i_window_low;
                if (accept && i_op == sbs_pkg::OP_WRITE) begin
                    o_req.we = 32'(i_entry_index) < 32'(sbs_pkg::TABLE_DEPTH);
                end
                if (accept && i_op == sbs_pkg::OP_SEARCH) begin
                    n_key = i_data_word;
                    n_lo  = i_window_low;
                    n_hi  = sat_hi;
                    if (i_window_low > sat_hi) begin
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_pos    = '0;
                    end
                end
            end
            sbs_pkg::ST_LOOK: begin
                rd_pos = (upd_lo < upd_hi) ? upd_mid : upd_lo;
                n_lo   = upd_lo;
                n_hi   = upd_hi;
            end
            sbs_pkg::ST_LAST: begin
                n_strobe = 1'b1;
                n_found  = i_rdata == r_key;
                n_pos    = (i_rdata == r_key) ? r_lo : '0;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
        o_req.raddr = rd_pos[sbs_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbs_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign busy       = r_state != sbs_pkg::ST_IDLE;
    assign o_strobe   = r_strobe;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

[hdl/sorted_table_binary_search.sv]
// Sorted table binary search, top level: controller plus table RAM.
// Write beats are stored at the accepting edge, give no result and leave busy low.
// A search holds busy while the window is halved and the last entry is compared, one RAM read
// each; the strobe follows in the cycle after the compare and the next beat can be taken in the
// strobe cycle. Empty window: strobe in the next cycle.
// Reset is synchronous and clears the controller only; the table contents are kept.
module sorted_table_binary_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [sbs_pkg::POS_W-1:0]         i_entry_index,
    input  logic signed [sbs_pkg::WORD_W-1:0] i_data_word,
    input  logic [sbs_pkg::POS_W-1:0]         i_window_low,
    input  logic [sbs_pkg::POS_W-1:0]         i_window_high,
    output logic                              o_strobe,
    output logic                              o_found,
    output logic [sbs_pkg::POS_W-1:0]         o_position
);

    sbs_pkg::t_ram_req                 ram_req;
    logic signed [sbs_pkg::WORD_W-1:0] ram_rdata;

    sbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_data_word   (i_data_word),
        .i_window_low  (i_window_low),
        .i_window_high (i_window_high),
        .i_rdata       (ram_rdata),
        .o_req         (ram_req),
        .o_strobe      (o_strobe),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    sbs_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for sorted_table_binary_search: fills the table, runs leftmost
// searches over sorted and disturbed windows and compares every result beat with a predictor.
// Depends on sbs_pkg and the sorted_table_binary_search top level.
module tb_top;

    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 200;
    localparam logic signed [sbs_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [sbs_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                      found;
        logic [sbs_pkg::POS_W-1:0] position;
    } t_hit;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_op;
    logic [sbs_pkg::POS_W-1:0]         i_entry_index;
    logic signed [sbs_pkg::WORD_W-1:0] i_data_word;
    logic [sbs_pkg::POS_W-1:0]         i_window_low;
    logic [sbs_pkg::POS_W-1:0]         i_window_high;
    logic                              o_strobe;
    logic                              o_found;
    logic [sbs_pkg::POS_W-1:0]         o_position;

    logic signed [sbs_pkg::WORD_W-1:0] shadow_table [sbs_pkg::TABLE_DEPTH];
    t_hit                     pending_hits [$];
    t_hit                     due_hit;
    bit                       quiet_stretch;
    int                       error_count;
    int                       cycle_count;
    int                       items_sent;
    int                       writes_sent;
    int                       searches_sent;
    int                       hits_seen;

    sorted_table_binary_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_data_word   (i_data_word),
        .i_window_low  (i_window_low),
        .i_window_high (i_window_high),
        .o_strobe      (o_strobe),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hits.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_hit leftmost_match(input logic signed [sbs_pkg::WORD_W-1:0] key,
                                            input logic [sbs_pkg::POS_W-1:0] low_in,
                                            input logic [sbs_pkg::POS_W-1:0] high_in);
        t_hit r;
        int   lo;
        int   hi;
        int   mid;
        r  = '0;
        lo = int'(low_in);
        hi = int'(high_in);
        if (hi > sbs_pkg::TABLE_DEPTH - 1)
            hi = sbs_pkg::TABLE_DEPTH - 1;
        if (lo > hi)
            return r;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (key <= shadow_table[mid[sbs_pkg::POS_W-1:0]])
                hi = mid;
            else
                lo = mid + 1;
        end
        if (shadow_table[lo[sbs_pkg::POS_W-1:0]] == key) begin
            r.found    = 1'b1;
            r.position = lo[sbs_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_stretch)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // key drawn from the window, nudged by one either way, or fully random
    function automatic logic signed [sbs_pkg::WORD_W-1:0] pick_key(input int lo, input int hi);
        logic signed [sbs_pkg::WORD_W-1:0] k;
        if (lo > hi)
            return $urandom;
        k = shadow_table[sbs_pkg::POS_W'($urandom_range(hi, lo))];
        case ($urandom_range(9, 0))
            0, 1:    k = k + 1;
            2:       k = k - 1;
            3, 4:    k = $urandom;
            default: ;
        endcase
        return k;
    endfunction

    function automatic longint step_up(input longint v, input int span);
        longint n;
        n = v;
        if ($urandom_range(6, 0) != 0)
            n = n + $urandom_range(span, 0);
        if (n > longint'(WORD_MAX))
            n = longint'(WORD_MAX);
        return n;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_hits.size() == 0) begin
                note_failure($sformatf("unexpected result beat found=%0b position=%0d",
                                       o_found, o_position));
            end else begin
                due_hit = pending_hits.pop_front();
                if (o_found !== due_hit.found || o_position !== due_hit.position)
                    note_failure($sformatf("found exp %0b got %0b, position exp %0d got %0d",
                                           due_hit.found, o_found, due_hit.position,
                                           o_position));
                if (o_found === 1'b1)
                    hits_seen++;
            end
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_beat(input logic op, input logic [sbs_pkg::POS_W-1:0] idx,
                             input logic signed [sbs_pkg::WORD_W-1:0] word,
                             input logic [sbs_pkg::POS_W-1:0] lo,
                             input logic [sbs_pkg::POS_W-1:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_data_word   <= word;
        i_window_low  <= lo;
        i_window_high <= hi;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (op == sbs_pkg::OP_WRITE) begin
            shadow_table[idx] = word;
            writes_sent++;
        end else begin
            pending_hits.push_back(leftmost_match(word, lo, hi));
            searches_sent++;
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_entry(input int idx, input logic signed [sbs_pkg::WORD_W-1:0] word);
        send_beat(sbs_pkg::OP_WRITE, sbs_pkg::POS_W'(idx), word,
                  sbs_pkg::POS_W'($urandom), sbs_pkg::POS_W'($urandom));
    endtask

    task automatic search_key(input logic signed [sbs_pkg::WORD_W-1:0] key,
                              input int lo, input int hi);
        send_beat(sbs_pkg::OP_SEARCH, sbs_pkg::POS_W'($urandom), key,
                  sbs_pkg::POS_W'(lo), sbs_pkg::POS_W'(hi));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_hits.size() != 0)
            @(negedge i_clk);
    endtask

    // only the two ends of the table are written here; searches stay inside them or use empty windows
    task automatic test_edges();
        write_entry(0, WORD_MIN);
        write_entry(1, -5);
        write_entry(2, -5);
        write_entry(3, 0);
        write_entry(1020, 7);
        write_entry(1021, 7);
        write_entry(1022, 100);
        write_entry(1023, WORD_MAX);
        search_key(WORD_MIN, 0, 3);
        search_key(-5, 0, 3);
        search_key(-5, 2, 3);
        search_key(0, 3, 3);
        search_key(1, 0, 3);
        search_key(-6, 0, 3);
        search_key(7, 1020, 1023);
        search_key(WORD_MAX, 1020, 1023);
        search_key(WORD_MAX, 1023, 1023);
        search_key(8, 1020, 1023);
        search_key(WORD_MIN, 1023, 1023);
        search_key(0, 3, 2);
        search_key(WORD_MAX, 1023, 0);
        search_key(-5, 1023, 1022);
    endtask

    task automatic test_full_table();
        longint v;
        int     lo;
        int     hi;
        v = longint'(WORD_MIN);
        for (int i = 0; i < sbs_pkg::TABLE_DEPTH; i++) begin
            write_entry(i, v[sbs_pkg::WORD_W-1:0]);
            v = step_up(v, 9000000);
        end
        search_key(WORD_MIN, 0, sbs_pkg::TABLE_DEPTH - 1);
        search_key(WORD_MAX, 0, sbs_pkg::TABLE_DEPTH - 1);
        for (int i = 0; i < 20; i++)
            search_key(pick_key(0, sbs_pkg::TABLE_DEPTH - 1), 0, sbs_pkg::TABLE_DEPTH - 1);
        for (int i = 0; i < 20; i++) begin
            lo = $urandom_range(sbs_pkg::TABLE_DEPTH - 1, 0);
            hi = $urandom_range(sbs_pkg::TABLE_DEPTH - 1, lo);
            search_key(pick_key(lo, hi), lo, hi);
        end
        // hold off until the table has answered everything
        wait_drained();
    endtask

    task automatic test_random_mix();
        int     r;
        int     len;
        int     base;
        int     lo;
        int     hi;
        int     tmp;
        longint v;
        int     span;
        int     target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            quiet_stretch = ($urandom_range(3, 0) == 0);
            r = $urandom_range(99, 0);
            if (r < 70) begin
                r   = $urandom_range(99, 0);
                len = (r < 80) ? $urandom_range(32, 1) :
                      (r < 95) ? $urandom_range(200, 33) :
                                 $urandom_range(sbs_pkg::TABLE_DEPTH, 201);
                base = $urandom_range(sbs_pkg::TABLE_DEPTH - len, 0);
                case ($urandom_range(3, 0))
                    0:       v = longint'(WORD_MIN);
                    1:       v = longint'($signed($urandom));
                    2:       v = $urandom_range(200, 0) - 100;
                    default: v = longint'($signed($urandom) >>> 8);
                endcase
                span = ($urandom_range(1, 0) == 0) ? 3 : (1 << 24);
                for (int i = 0; i < len; i++) begin
                    write_entry(base + i, v[sbs_pkg::WORD_W-1:0]);
                    v = step_up(v, span);
                end
                repeat ($urandom_range(6, 1)) begin
                    lo = $urandom_range(base + len - 1, base);
                    hi = $urandom_range(base + len - 1, lo);
                    tmp = lo;
                    if ($urandom_range(9, 0) == 0 && lo < hi) begin
                        lo = hi;
                        hi = tmp;
                    end
                    search_key(pick_key(lo, hi), lo, hi);
                end
            end else if (r < 85) begin
                // stray writes that break the ordering locally
                repeat ($urandom_range(5, 1))
                    write_entry($urandom_range(sbs_pkg::TABLE_DEPTH - 1, 0), $urandom);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    lo = $urandom_range(sbs_pkg::TABLE_DEPTH - 1, 0);
                    hi = $urandom_range(sbs_pkg::TABLE_DEPTH - 1, 0);
                    search_key(pick_key(lo, hi), lo, hi);
                end
            end
            if ($urandom_range(19, 0) == 0)
                wait_drained();
        end
        quiet_stretch = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = sbs_pkg::OP_WRITE;
        i_entry_index = '0;
        i_data_word   = '0;
        i_window_low  = '0;
        i_window_high = '0;
        quiet_stretch = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        items_sent    = 0;
        writes_sent   = 0;
        searches_sent = 0;
        hits_seen     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edges();
        test_full_table();
        test_random_mix();

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (pending_hits.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_hits.size()));

        $display("Run covered %0d table writes and %0d searches (%0d hits), including",
                 writes_sent, searches_sent, hits_seen);
        $display("edge entries, a full-table window, empty windows and disturbed ordering.");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hdl/sbs_pkg.sv
hdl/sbs_ram.sv
hdl/sbs_ctrl.sv
hdl/sorted_table_binary_search.sv
tb/tb_top.sv
